FILE: rtl/jhec_pkg.sv
// package for the jpeg huffman entropy coder
// holds code tables and size helpers; no dependencies
`default_nettype none
package jhec_pkg;

  localparam int CoefW = 11;
  localparam int BitsW = 27;
  localparam int LenW  = 5;
  localparam logic [7:0] AcZrlIndex = 8'd151;
  localparam logic [7:0] AcRun15Base = 8'd151;
  localparam logic [7:0] AcEobIndex = 8'd0;

  typedef struct packed {
    logic [BitsW-1:0] code_bits;
    logic [LenW-1:0]  code_length;
    logic             block_end;
  } result_t;

  function automatic logic [3:0] size_of(input logic [11:0] mag);
    logic [3:0] s;
    s = 4'd0;
    for (int i = 0; i < 12; i++) begin
      if (mag[i]) s = 4'(i + 1);
    end
    return s;
  endfunction

  function automatic logic [15:0] dc_code(input logic tab, input logic [3:0] s);
    logic [15:0] c;
    c = 16'd0;
    if (!tab) begin
      unique case (s)
        4'd0: c = 16'd0;   4'd1: c = 16'd2;   4'd2: c = 16'd3;   4'd3: c = 16'd4;
        4'd4: c = 16'd5;   4'd5: c = 16'd6;   4'd6: c = 16'd14;  4'd7: c = 16'd30;
        4'd8: c = 16'd62;  4'd9: c = 16'd126; 4'd10: c = 16'd254; 4'd11: c = 16'd510;
        default: c = 16'd0;
      endcase
    end else begin
      unique case (s)
        4'd0: c = 16'd0;    4'd1: c = 16'd1;    4'd2: c = 16'd2;    4'd3: c = 16'd6;
        4'd4: c = 16'd14;   4'd5: c = 16'd30;   4'd6: c = 16'd62;   4'd7: c = 16'd126;
        4'd8: c = 16'd254;  4'd9: c = 16'd510;  4'd10: c = 16'd1022; 4'd11: c = 16'd2046;
        default: c = 16'd0;
      endcase
    end
    return c;
  endfunction

  function automatic logic [4:0] dc_len(input logic tab, input logic [3:0] s);
    logic [4:0] l;
    if (!tab) l = (s == 4'd0) ? 5'd2 : (s < 4'd6) ? 5'd3 : 5'(s - 4'd2);
    else      l = (s < 4'd3) ? 5'd2 : 5'(s);
    return l;
  endfunction

  localparam logic [15:0] AcCode [2][162] = '{
    '{16'd10,16'd0,16'd1,16'd4,16'd11,16'd26,16'd120,16'd248,16'd1014,16'd65410,16'd65411,
      16'd12,16'd27,16'd121,16'd502,16'd2038,16'd65412,16'd65413,16'd65414,16'd65415,16'd65416,
      16'd28,16'd249,16'd1015,16'd4084,16'd65417,16'd65418,16'd65419,16'd65420,16'd65421,16'd65422,
      16'd58,16'd503,16'd4085,16'd65423,16'd65424,16'd65425,16'd65426,16'd65427,16'd65428,16'd65429,
      16'd59,16'd1016,16'd65430,16'd65431,16'd65432,16'd65433,16'd65434,16'd65435,16'd65436,16'd65437,
      16'd122,16'd2039,16'd65438,16'd65439,16'd65440,16'd65441,16'd65442,16'd65443,16'd65444,16'd65445,
      16'd123,16'd4086,16'd65446,16'd65447,16'd65448,16'd65449,16'd65450,16'd65451,16'd65452,16'd65453,
      16'd250,16'd4087,16'd65454,16'd65455,16'd65456,16'd65457,16'd65458,16'd65459,16'd65460,16'd65461,
      16'd504,16'd32704,16'd65462,16'd65463,16'd65464,16'd65465,16'd65466,16'd65467,16'd65468,16'd65469,
      16'd505,16'd65470,16'd65471,16'd65472,16'd65473,16'd65474,16'd65475,16'd65476,16'd65477,16'd65478,
      16'd506,16'd65479,16'd65480,16'd65481,16'd65482,16'd65483,16'd65484,16'd65485,16'd65486,16'd65487,
      16'd1017,16'd65488,16'd65489,16'd65490,16'd65491,16'd65492,16'd65493,16'd65494,16'd65495,16'd65496,
      16'd1018,16'd65497,16'd65498,16'd65499,16'd65500,16'd65501,16'd65502,16'd65503,16'd65504,16'd65505,
      16'd2040,16'd65506,16'd65507,16'd65508,16'd65509,16'd65510,16'd65511,16'd65512,16'd65513,16'd65514,
      16'd65515,16'd65516,16'd65517,16'd65518,16'd65519,16'd65520,16'd65521,16'd65522,16'd65523,16'd65524,
      16'd2041,16'd65525,16'd65526,16'd65527,16'd65528,16'd65529,16'd65530,16'd65531,16'd65532,16'd65533,
      16'd65534},
    '{16'd0,16'd1,16'd4,16'd10,16'd24,16'd25,16'd56,16'd120,16'd500,16'd1014,16'd4084,
      16'd11,16'd57,16'd246,16'd501,16'd2038,16'd4085,16'd65416,16'd65417,16'd65418,16'd65419,
      16'd26,16'd247,16'd1015,16'd4086,16'd32706,16'd65420,16'd65421,16'd65422,16'd65423,16'd65424,
      16'd27,16'd248,16'd1016,16'd4087,16'd65425,16'd65426,16'd65427,16'd65428,16'd65429,16'd65430,
      16'd58,16'd502,16'd65431,16'd65432,16'd65433,16'd65434,16'd65435,16'd65436,16'd65437,16'd65438,
      16'd59,16'd1017,16'd65439,16'd65440,16'd65441,16'd65442,16'd65443,16'd65444,16'd65445,16'd65446,
      16'd121,16'd2039,16'd65447,16'd65448,16'd65449,16'd65450,16'd65451,16'd65452,16'd65453,16'd65454,
      16'd122,16'd2040,16'd65455,16'd65456,16'd65457,16'd65458,16'd65459,16'd65460,16'd65461,16'd65462,
      16'd249,16'd65463,16'd65464,16'd65465,16'd65466,16'd65467,16'd65468,16'd65469,16'd65470,16'd65471,
      16'd503,16'd65472,16'd65473,16'd65474,16'd65475,16'd65476,16'd65477,16'd65478,16'd65479,16'd65480,
      16'd504,16'd65481,16'd65482,16'd65483,16'd65484,16'd65485,16'd65486,16'd65487,16'd65488,16'd65489,
      16'd505,16'd65490,16'd65491,16'd65492,16'd65493,16'd65494,16'd65495,16'd65496,16'd65497,16'd65498,
      16'd506,16'd65499,16'd65500,16'd65501,16'd65502,16'd65503,16'd65504,16'd65505,16'd65506,16'd65507,
      16'd2041,16'd65508,16'd65509,16'd65510,16'd65511,16'd65512,16'd65513,16'd65514,16'd65515,16'd65516,
      16'd16352,16'd65517,16'd65518,16'd65519,16'd65520,16'd65521,16'd65522,16'd65523,16'd65524,16'd65525,
      16'd1018,16'd32707,16'd65526,16'd65527,16'd65528,16'd65529,16'd65530,16'd65531,16'd65532,16'd65533,
      16'd65534}
  };

  localparam logic [4:0] AcLen [2][162] = '{
    '{5'd4,5'd2,5'd2,5'd3,5'd4,5'd5,5'd7,5'd8,5'd10,5'd16,5'd16,
      5'd4,5'd5,5'd7,5'd9,5'd11,5'd16,5'd16,5'd16,5'd16,5'd16,
      5'd5,5'd8,5'd10,5'd12,5'd16,5'd16,5'd16,5'd16,5'd16,5'd16,
      5'd6,5'd9,5'd12,5'd16,5'd16,5'd16,5'd16,5'd16,5'd16,5'd16,
      5'd6,5'd10,5'd16,5'd16,5'd16,5'd16,5'd16,5'd16,5'd16,5'd16,
      5'd7,5'd11,5'd16,5'd16,5'd16,5'd16,5'd16,5'd16,5'd16,5'd16,
      5'd7,5'd12,5'd16,5'd16,5'd16,5'd16,5'd16,5'd16,5'd16,5'd16,
      5'd8,5'd12,5'd16,5'd16,5'd16,5'd16,5'd16,5'd16,5'd16,5'd16,
      5'd9,5'd15,5'd16,5'd16,5'd16,5'd16,5'd16,5'd16,5'd16,5'd16,
      5'd9,5'd16,5'd16,5'd16,5'd16,5'd16,5'd16,5'd16,5'd16,5'd16,
      5'd9,5'd16,5'd16,5'd16,5'd16,5'd16,5'd16,5'd16,5'd16,5'd16,
      5'd10,5'd16,5'd16,5'd16,5'd16,5'd16,5'd16,5'd16,5'd16,5'd16,
      5'd10,5'd16,5'd16,5'd16,5'd16,5'd16,5'd16,5'd16,5'd16,5'd16,
      5'd11,5'd16,5'd16,5'd16,5'd16,5'd16,5'd16,5'd16,5'd16,5'd16,
      5'd16,5'd16,5'd16,5'd16,5'd16,5'd16,5'd16,5'd16,5'd16,5'd16,
      5'd11,5'd16,5'd16,5'd16,5'd16,5'd16,5'd16,5'd16,5'd16,5'd16,
      5'd16},
    '{5'd2,5'd2,5'd3,5'd4,5'd5,5'd5,5'd6,5'd7,5'd9,5'd10,5'd12,
      5'd4,5'd6,5'd8,5'd9,5'd11,5'd12,5'd16,5'd16,5'd16,5'd16,
      5'd5,5'd8,5'd10,5'd12,5'd15,5'd16,5'd16,5'd16,5'd16,5'd16,
      5'd5,5'd8,5'd10,5'd12,5'd16,5'd16,5'd16,5'd16,5'd16,5'd16,
      5'd6,5'd9,5'd16,5'd16,5'd16,5'd16,5'd16,5'd16,5'd16,5'd16,
      5'd6,5'd10,5'd16,5'd16,5'd16,5'd16,5'd16,5'd16,5'd16,5'd16,
      5'd7,5'd11,5'd16,5'd16,5'd16,5'd16,5'd16,5'd16,5'd16,5'd16,
      5'd7,5'd11,5'd16,5'd16,5'd16,5'd16,5'd16,5'd16,5'd16,5'd16,
      5'd8,5'd16,5'd16,5'd16,5'd16,5'd16,5'd16,5'd16,5'd16,5'd16,
      5'd9,5'd16,5'd16,5'd16,5'd16,5'd16,5'd16,5'd16,5'd16,5'd16,
      5'd9,5'd16,5'd16,5'd16,5'd16,5'd16,5'd16,5'd16,5'd16,5'd16,
      5'd9,5'd16,5'd16,5'd16,5'd16,5'd16,5'd16,5'd16,5'd16,5'd16,
      5'd9,5'd16,5'd16,5'd16,5'd16,5'd16,5'd16,5'd16,5'd16,5'd16,
      5'd11,5'd16,5'd16,5'd16,5'd16,5'd16,5'd16,5'd16,5'd16,5'd16,
      5'd14,5'd16,5'd16,5'd16,5'd16,5'd16,5'd16,5'd16,5'd16,5'd16,
      5'd10,5'd15,5'd16,5'd16,5'd16,5'd16,5'd16,5'd16,5'd16,5'd16,
      5'd16}
  };

endpackage
`default_nettype wire

FILE: rtl/jpeg_huffman_entropy_coder_unit.sv
// top level of the baseline jpeg huffman entropy coder
// depends on jhec_pkg and jhec_result_fifo
`default_nettype none
// Takes one quantized coefficient per cycle in zigzag order (64 per block) and
// emits up to four code words per coefficient (ZRL words plus one run/size, EOB or DC
// code). Coding is done in the accept cycle from the predictor, run and position
// registers; words go into an eight-entry queue, and input is accepted while at
// least four entries are free, so one coefficient per cycle is sustained except
// when ZRL bursts or m_tready stalls fill the queue faster than the output drains one word a cycle.
module jpeg_huffman_entropy_coder_unit
  import jhec_pkg::*;
#(
  parameter int COMPONENTS = 3
) (
  input  wire logic        clk,
  input  wire logic        rst,
  input  wire logic        s_tvalid,
  output logic             s_tready,
  input  wire logic [15:0] s_tdata,  // coefficient[10:0], zero fill
  input  wire logic [1:0]  s_tuser,  // component
  output logic             m_tvalid,
  input  wire logic        m_tready,
  output logic [31:0]      m_tdata,  // code_bits[26:0], code_length[31:27]
  output logic             m_tuser,  // block_end
  output logic             m_tlast   // last_of_item
);

  localparam int PiW = (COMPONENTS > 1) ? $clog2(COMPONENTS) : 1;

  logic signed [11:0] dc_predictor [COMPONENTS];
  logic [5:0]  zero_run;
  logic [5:0]  block_position;

  logic        accept;
  logic signed [10:0] v;
  logic        tab;
  logic [PiW-1:0] pi;
  logic signed [11:0] diff;
  logic [11:0] mag;
  logic [3:0]  s;
  logic [11:0] amp;
  logic [15:0] hcode;
  logic [4:0]  hlen;
  logic [7:0]  idx;
  logic [1:0]  zrl_n;
  logic [3:0]  run_lo;
  logic [2:0]  count;
  logic        is_dc, is_zero, at_end;
  result_t     res [4];
  result_t     coded;
  logic        f_ne;
  logic [3:0]  f_free;
  result_t     f_head;
  logic        f_last;

  assign accept  = s_tvalid && s_tready;
  assign s_tready = f_free >= 4'd4;
  assign v       = s_tdata[10:0];
  assign tab     = s_tuser != 2'd0;
  assign pi      = ({30'd0, s_tuser} < 32'(COMPONENTS)) ? PiW'(s_tuser) : PiW'(COMPONENTS - 1);
  assign is_dc   = block_position == 6'd0;
  assign is_zero = v == 11'sd0;
  assign at_end  = block_position == 6'd63;

  always_comb begin
    logic signed [10:0] vs;
    vs    = (v == -11'sd1024) ? -11'sd1023 : v;
    diff  = is_dc ? (12'(v) - dc_predictor[pi]) : 12'(vs);
    mag   = diff[11] ? 12'(-diff) : diff;
    s     = size_of(mag);
    amp   = (diff[11] ? 12'(diff - 12'sd1) : 12'(diff)) & ((12'd1 << s) - 12'd1);
    zrl_n = (zero_run[5:4] == 2'd3) ? 2'd3 : zero_run[5:4];
    run_lo = zero_run[3:0];
    idx   = (run_lo == 4'd15) ? 8'(AcRun15Base + 8'(s)) : 8'(8'(run_lo) * 8'd10 + 8'(s));
    if (is_dc) begin
      hcode = dc_code(tab, s);
      hlen  = dc_len(tab, s);
    end else if (is_zero) begin
      hcode = AcCode[tab][AcEobIndex];
      hlen  = AcLen[tab][AcEobIndex];
    end else begin
      hcode = AcCode[tab][idx];
      hlen  = AcLen[tab][idx];
    end
    coded.code_bits   = (is_zero && !is_dc) ? 27'(hcode)
                        : ((27'(hcode) << s) | 27'(amp));
    coded.code_length = (is_zero && !is_dc) ? hlen : 5'(hlen + 5'(s));
    coded.block_end   = at_end;
    for (int i = 0; i < 4; i++) begin
      res[i].code_bits   = 27'(AcCode[tab][AcZrlIndex]);
      res[i].code_length = AcLen[tab][AcZrlIndex];
      res[i].block_end   = 1'b0;
    end
    count = 3'd0;
    if (is_dc || (is_zero && at_end)) begin
      res[0] = coded;
      count  = 3'd1;
    end else if (!is_zero) begin
      res[zrl_n] = coded;
      count      = 3'(zrl_n) + 3'd1;
    end
  end

  jhec_result_fifo u_fifo (
    .clk        (clk),
    .rst        (rst),
    .push       (accept && count != 3'd0),
    .push_count (count),
    .push_data  (res),
    .pop        (m_tvalid && m_tready),
    .not_empty  (f_ne),
    .free_count (f_free),
    .head       (f_head),
    .head_last  (f_last)
  );

  assign m_tvalid = f_ne;
  assign m_tdata  = {f_head.code_length, f_head.code_bits};
  assign m_tuser  = f_head.block_end;
  assign m_tlast  = f_last;

  always_ff @(posedge clk) begin
    if (rst) begin
      for (int i = 0; i < COMPONENTS; i++) dc_predictor[i] <= '0;
      zero_run       <= '0;
      block_position <= '0;
    end else if (accept) begin
      block_position <= block_position + 6'd1;
      if (is_dc) begin
        dc_predictor[pi] <= 12'(v);
        zero_run <= '0;
      end else if (is_zero && !at_end) begin
        zero_run <= zero_run + 6'd1;
      end else begin
        zero_run <= '0;
      end
    end
  end

endmodule
`default_nettype wire

FILE: rtl/jhec_result_fifo.sv
// eight-deep result queue with registered output between coder and stream output
// depends on jhec_pkg
`default_nettype none
module jhec_result_fifo
  import jhec_pkg::*;
(
  input  wire logic    clk,
  input  wire logic    rst,
  input  wire logic    push,
  input  wire logic [2:0] push_count,
  input  wire result_t push_data [4],
  input  wire logic    pop,
  output logic         not_empty,
  output logic [3:0]   free_count,
  output result_t      head,
  output logic         head_last
);

  localparam int Depth = 8;

  result_t    mem [Depth];
  logic       mem_last [Depth];
  logic [2:0] rd_ptr;
  logic [2:0] wr_ptr;
  logic [3:0] fill;

  assign not_empty  = fill != 4'd0;
  assign free_count = 4'(Depth) - fill;
  assign head       = mem[rd_ptr];
  assign head_last  = mem_last[rd_ptr];

  always_ff @(posedge clk) begin
    if (rst) begin
      rd_ptr <= '0;
      wr_ptr <= '0;
      fill   <= '0;
    end else begin
      if (push) begin
        for (int i = 0; i < 4; i++) begin
          if (3'(i) < push_count) begin
            mem[3'(wr_ptr + 3'(i))]      <= push_data[i];
            mem_last[3'(wr_ptr + 3'(i))] <= (3'(i) == push_count - 3'd1);
          end
        end
        wr_ptr <= wr_ptr + push_count;
      end
      if (pop) rd_ptr <= rd_ptr + 3'd1;
      fill <= fill + (push ? {1'b0, push_count} : 4'd0) - (pop ? 4'd1 : 4'd0);
    end
  end

endmodule
`default_nettype wire

FILE: rtl/jhec_checker.sv
// port-level checks for the jpeg huffman entropy coder
// depends on jpeg_huffman_entropy_coder_unit, bound below
`default_nettype none
module jhec_checker (
  input wire logic        clk,
  input wire logic        rst,
  input wire logic        s_tready,
  input wire logic        m_tvalid,
  input wire logic        m_tready,
  input wire logic [31:0] m_tdata,
  input wire logic        m_tuser,
  input wire logic        m_tlast
);

  a_len_nonzero: assert property (@(posedge clk) disable iff (rst)
    m_tvalid |-> m_tdata[31:27] != 5'd0) else $error("zero length word");

  a_end_is_last: assert property (@(posedge clk) disable iff (rst)
    m_tvalid && m_tuser |-> m_tlast) else $error("block end not last");

  a_hold: assert property (@(posedge clk) disable iff (rst)
    m_tvalid && !m_tready |=> m_tvalid && $stable(m_tdata)) else $error("word dropped");

  a_reset_idle: assert property (@(posedge clk)
    $past(rst) |-> !m_tvalid && s_tready) else $error("not idle after reset");

endmodule

bind jpeg_huffman_entropy_coder_unit jhec_checker u_jhec_checker (
  .clk(clk), .rst(rst), .s_tready(s_tready), .m_tvalid(m_tvalid),
  .m_tready(m_tready), .m_tdata(m_tdata), .m_tuser(m_tuser), .m_tlast(m_tlast)
);
`default_nettype wire

FILE: tb/sv/tb_jpeg_huffman_entropy_coder_unit.sv
// testbench for the jpeg huffman entropy coder unit
// drives coefficient blocks, predicts code words with its own coder and checks each word
// depends on jhec_pkg and the rtl of jpeg_huffman_entropy_coder_unit
`timescale 1ns / 1ps

class code_word_scoreboard;
  typedef struct packed {
    logic [26:0] bits;
    logic [4:0]  len;
    logic        bend;
    logic        last;
  } word_t;

  static const logic [15:0] DcCodeL [12] = '{0, 2, 3, 4, 5, 6, 14, 30, 62, 126, 254, 510};
  static const logic [15:0] DcCodeC [12] = '{0, 1, 2, 6, 14, 30, 62, 126, 254, 510, 1022, 2046};
  static const logic [4:0] DcLenL [12] = '{2, 3, 3, 3, 3, 3, 4, 5, 6, 7, 8, 9};
  static const logic [4:0] DcLenC [12] = '{2, 2, 2, 3, 4, 5, 6, 7, 8, 9, 10, 11};

  word_t pending_words[$];
  int signed dc_pred[3];
  int zero_run;
  int position;
  int mismatches;

  function void reset_state();
    pending_words.delete();
    foreach (dc_pred[i]) dc_pred[i] = 0;
    zero_run = 0;
    position = 0;
    mismatches = 0;
  endfunction

  function int bit_size(int signed v);
    int m;
    int s;
    m = v < 0 ? -v : v;
    s = 0;
    while (m >> s != 0) s++;
    return s;
  endfunction

  function void push_word(logic [15:0] code, logic [4:0] clen, int signed v, int s, bit bend);
    word_t w;
    int unsigned mask;
    int unsigned amp;
    mask = (1 << s) - 1;
    amp = v < 0 ? (v + mask) & mask : v & mask;
    w.bits = 27'(({16'd0, code} << s) | amp);
    w.len = 5'(clen + s);
    w.bend = bend;
    w.last = 0;
    pending_words.insert(pending_words.size(), w);
  endfunction

  function void note_coefficient(logic [10:0] coef, logic [1:0] comp);
    int signed v;
    int signed diff;
    int s;
    int idx;
    int produced;
    int tab;
    int pi;
    v = $signed(coef);
    tab = comp != 0;
    produced = 0;
    if (position == 0) begin
      pi = comp < 3 ? comp : 2;
      diff = v - dc_pred[pi];
      s = bit_size(diff);
      dc_pred[pi] = v;
      push_word(tab ? DcCodeC[s] : DcCodeL[s], tab ? DcLenC[s] : DcLenL[s], diff, s, 0);
      produced = 1;
      zero_run = 0;
    end else if (v == 0) begin
      if (position == 63) begin
        push_word(jhec_pkg::AcCode[tab][jhec_pkg::AcEobIndex],
                  jhec_pkg::AcLen[tab][jhec_pkg::AcEobIndex], 0, 0, 1);
        produced = 1;
      end else zero_run = (zero_run + 1) & 63;
    end else begin
      if (v < -1023) v = -1023;
      s = bit_size(v);
      while (zero_run >= 16 && produced < 3) begin
        push_word(jhec_pkg::AcCode[tab][jhec_pkg::AcZrlIndex],
                  jhec_pkg::AcLen[tab][jhec_pkg::AcZrlIndex], 0, 0, 0);
        produced++;
        zero_run -= 16;
      end
      zero_run &= 15;
      idx = zero_run == 15 ? jhec_pkg::AcRun15Base + s : zero_run * 10 + s;
      push_word(jhec_pkg::AcCode[tab][idx], jhec_pkg::AcLen[tab][idx], v, s, position == 63);
      produced++;
      zero_run = 0;
    end
    if (position == 63) zero_run = 0;
    position = (position + 1) & 63;
    if (produced > 0) pending_words[$].last = 1;
  endfunction

  function void check_word(logic [31:0] data, logic bend, logic last);
    word_t exp_w;
    word_t got;
    got = '{data[26:0], data[31:27], bend, last};
    if (pending_words.size() == 0) begin
      mismatches++;
      if (mismatches <= 10) $display("unexpected word %h bend %0b last %0b", data, bend, last);
      return;
    end
    exp_w = pending_words.pop_front();
    if (got !== exp_w) begin
      mismatches++;
      if (mismatches <= 10)
        $display("word mismatch: exp bits %h len %0d bend %0b last %0b,",
                 exp_w.bits, exp_w.len, exp_w.bend, exp_w.last,
                 " got bits %h len %0d bend %0b last %0b",
                 got.bits, got.len, got.bend, got.last);
    end
  endfunction
endclass

module tb_jpeg_huffman_entropy_coder_unit;
  localparam int WatchdogLimit = 5000;

  logic clk = 0;
  logic rst = 1;
  logic s_tvalid = 0;
  logic s_tready;
  logic [15:0] s_tdata = '0;
  logic [1:0] s_tuser = '0;
  logic m_tvalid;
  logic m_tready = 0;
  logic [31:0] m_tdata;
  logic m_tuser;
  logic m_tlast;

  code_word_scoreboard coder_sb;
  bit calm_phase = 0;
  bit stimulus_done = 0;
  int idle_cycles = 0;

  always #5 clk = ~clk;

  jpeg_huffman_entropy_coder_unit u_top (
    .clk(clk), .rst(rst),
    .s_tvalid(s_tvalid), .s_tready(s_tready), .s_tdata(s_tdata), .s_tuser(s_tuser),
    .m_tvalid(m_tvalid), .m_tready(m_tready), .m_tdata(m_tdata), .m_tuser(m_tuser),
    .m_tlast(m_tlast)
  );

  always @(posedge clk) begin
    if (!rst) begin
      if (s_tvalid && s_tready) coder_sb.note_coefficient(s_tdata[10:0], s_tuser);
      if (m_tvalid && m_tready) coder_sb.check_word(m_tdata, m_tuser, m_tlast);
      if ((s_tvalid && s_tready) || (m_tvalid && m_tready)) idle_cycles = 0;
      else if (!(stimulus_done && coder_sb.pending_words.size() == 0)) idle_cycles++;
      if (idle_cycles >= WatchdogLimit) begin
        $display("CHECKS FAILED");
        $finish;
      end
    end
  end

  always @(negedge clk) begin
    if (rst) m_tready <= 0;
    else m_tready <= calm_phase || ($urandom_range(99) >= 21);
  end

  // returns at the accepting edge with tvalid still high
  task automatic send_coefficient(input logic [10:0] coef, input logic [1:0] comp);
    @(negedge clk);
    if (!calm_phase) begin
      while ($urandom_range(99) < 21) begin
        s_tvalid <= 0;
        @(negedge clk);
      end
    end
    s_tvalid <= 1;
    s_tdata <= {5'd0, coef};
    s_tuser <= comp;
    @(posedge clk);
    while (!s_tready) @(posedge clk);
  endtask

  // one block; style picks density of nonzero terms
  task automatic send_block(input logic [1:0] comp, input int style);
    logic [10:0] c;
    for (int p = 0; p < 64; p++) begin
      case (style)
        0: c = ($urandom_range(99) < 8) ? 11'($urandom_range(2047)) : 11'd0;
        1: c = ($urandom_range(99) < 40) ? 11'($signed($urandom_range(14)) - 7) : 11'd0;
        default: c = 11'($urandom_range(2047));
      endcase
      send_coefficient(c, ($urandom_range(15) == 0) ? 2'($urandom_range(3)) : comp);
    end
  endtask

  task automatic drain_words();
    @(negedge clk);
    s_tvalid <= 0;
    while (coder_sb.pending_words.size() != 0) @(posedge clk);
  endtask

  initial begin
    coder_sb = new();
    coder_sb.reset_state();
    repeat (12) @(posedge clk);
    @(negedge clk);
    rst <= 0;

    // directed block: dc extremes, zero runs past 16 and 32, nonzero last term
    send_coefficient(11'h400, 0);
    for (int p = 1; p < 20; p++) send_coefficient(11'd0, 0);
    send_coefficient(11'h400, 0);
    send_coefficient(11'h3ff, 1);
    send_coefficient(11'h7ff, 2);
    send_coefficient(11'd1, 3);
    for (int p = 24; p < 63; p++) send_coefficient(11'd0, 1);
    send_coefficient(11'h3ff, 0);
    // block with a dc difference of 2047 and all-zero ac, ending in eob
    send_coefficient(11'h3ff, 0);
    for (int p = 1; p < 64; p++) send_coefficient(11'd0, 2);
    drain_words();
    // dc on unknown component and chroma extreme after a run past 48
    send_coefficient(11'h400, 3);
    for (int p = 1; p < 64; p++) send_coefficient(p == 60 ? 11'h400 : 11'd0, 3);

    calm_phase = 1;
    send_block(0, 2);
    calm_phase = 0;
    for (int b = 0; b < 1; b++) send_block(2'($urandom_range(2)), b % 3);
    drain_words();
    send_block(2'($urandom_range(3)), 1);

    stimulus_done = 1;
    drain_words();
    repeat (20) @(posedge clk);
    if (coder_sb.mismatches == 0 && coder_sb.pending_words.size() == 0)
      $display("ALL CHECKS PASSED");
    else
      $display("CHECKS FAILED");
    $finish;
  end
endmodule
